/* rtl/assert_macros.svh */
// Assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) (rst) |=> (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_RST(label, clk, rst, prop, msg)
`endif
`endif

/* rtl/aavr_pkg.sv */
package aavr_pkg;
   localparam int ATAN_ENTRIES = 24;
   localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
   localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;
   localparam logic signed [16:0] FULL_TURN = 17'sd46080;
   localparam logic signed [16:0] HALF_TURN = 17'sd23040;
   localparam logic signed [16:0] QUARTER_TURN = 17'sd11520;

   typedef logic signed [31:0] vec_type [3];
   typedef logic signed [15:0] axis_type [3];

   function automatic logic signed [31:0] atan_q23(input int idx);
      logic signed [31:0] t [ATAN_ENTRIES];
      t = '{32'sd377487360, 32'sd222843801, 32'sd117744544, 32'sd59768969,
            32'sd30000467, 32'sd15014858, 32'sd7509261, 32'sd3754860,
            32'sd1877459, 32'sd938733, 32'sd469367, 32'sd234683,
            32'sd117342, 32'sd58671, 32'sd29335, 32'sd14668,
            32'sd7334, 32'sd3667, 32'sd1833, 32'sd917,
            32'sd458, 32'sd229, 32'sd115, 32'sd57};
      return t[idx];
   endfunction
endpackage

/* rtl/aavr_cordic.sv */
// Pipelined sine/cosine, angle in 1/128-degree units; one stage per iteration.
`include "assert_macros.svh"
module aavr_cordic #(
   parameter int STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic signed [16:0] in_angle,
   input  aavr_pkg::vec_type  in_vec,
   input  aavr_pkg::axis_type in_axis,
   output logic               out_valid,
   output logic signed [31:0] out_cos,
   output logic signed [31:0] out_sin,
   output aavr_pkg::vec_type  out_vec,
   output aavr_pkg::axis_type out_axis
);
   localparam int N = (STAGES < aavr_pkg::ATAN_ENTRIES) ? STAGES : aavr_pkg::ATAN_ENTRIES;

   // stage 0: angle reduction
   logic                v0_ff;
   logic                flip0_ff;
   logic signed [31:0]  z0_ff;
   aavr_pkg::vec_type   vec0_ff;
   aavr_pkg::axis_type  axis0_ff;
   logic signed [17:0]  a_in;
   logic                flip_in;
   logic signed [17:0]  ar_in;

   // |angle| < 2 turns, so one compare and subtract gives the remainder
   always_comb begin
      a_in = 18'(in_angle);
      if (a_in >= 18'(aavr_pkg::FULL_TURN)) begin
         a_in = a_in - 18'(aavr_pkg::FULL_TURN);
      end else if (a_in <= -18'(aavr_pkg::FULL_TURN)) begin
         a_in = a_in + 18'(aavr_pkg::FULL_TURN);
      end
      if (a_in > 18'(aavr_pkg::HALF_TURN)) a_in = a_in - 18'(aavr_pkg::FULL_TURN);
      if (a_in < -18'(aavr_pkg::HALF_TURN)) a_in = a_in + 18'(aavr_pkg::FULL_TURN);
      flip_in = 1'b0;
      ar_in = a_in;
      if (a_in > 18'(aavr_pkg::QUARTER_TURN)) begin
         ar_in = a_in - 18'(aavr_pkg::HALF_TURN);
         flip_in = 1'b1;
      end else if (a_in < -18'(aavr_pkg::QUARTER_TURN)) begin
         ar_in = a_in + 18'(aavr_pkg::HALF_TURN);
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= in_valid;
      end
      if (adv) begin
         flip0_ff <= flip_in;
         z0_ff <= {ar_in[15:0], 16'd0};
         vec0_ff <= in_vec;
         axis0_ff <= in_axis;
      end
   end

   logic                vs_ff   [N];
   logic                flips_ff[N];
   logic signed [33:0]  xs_ff   [N];
   logic signed [33:0]  ys_ff   [N];
   logic signed [31:0]  zs_ff   [N];
   aavr_pkg::vec_type   vecs_ff [N];
   aavr_pkg::axis_type  axiss_ff[N];

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic                pv, pf;
      logic signed [33:0]  px, py;
      logic signed [31:0]  pz;
      aavr_pkg::vec_type   pvec;
      aavr_pkg::axis_type  pax;
      logic signed [33:0]  x_in, y_in;
      logic signed [31:0]  z_in;
      if (i == 0) begin : g_first
         assign pv = v0_ff;
         assign pf = flip0_ff;
         assign px = 34'(aavr_pkg::CORDIC_GAIN_Q30);
         assign py = '0;
         assign pz = z0_ff;
         assign pvec = vec0_ff;
         assign pax = axis0_ff;
      end else begin : g_next
         assign pv = vs_ff[i-1];
         assign pf = flips_ff[i-1];
         assign px = xs_ff[i-1];
         assign py = ys_ff[i-1];
         assign pz = zs_ff[i-1];
         assign pvec = vecs_ff[i-1];
         assign pax = axiss_ff[i-1];
      end
      always_comb begin
         if (!pz[31]) begin
            x_in = px - (py >>> i);
            y_in = py + (px >>> i);
            z_in = pz - aavr_pkg::atan_q23(i);
         end else begin
            x_in = px + (py >>> i);
            y_in = py - (px >>> i);
            z_in = pz + aavr_pkg::atan_q23(i);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vs_ff[i] <= 1'b0;
         end else if (adv) begin
            vs_ff[i] <= pv;
         end
         if (adv) begin
            flips_ff[i] <= pf;
            xs_ff[i] <= x_in;
            ys_ff[i] <= y_in;
            zs_ff[i] <= z_in;
            vecs_ff[i] <= pvec;
            axiss_ff[i] <= pax;
         end
      end
   end

   logic signed [33:0] xf, yf;
   assign xf = flips_ff[N-1] ? -xs_ff[N-1] : xs_ff[N-1];
   assign yf = flips_ff[N-1] ? -ys_ff[N-1] : ys_ff[N-1];
   assign out_valid = vs_ff[N-1];
   assign out_cos = xf[31:0];
   assign out_sin = yf[31:0];
   assign out_vec = vecs_ff[N-1];
   assign out_axis = axiss_ff[N-1];

   `ASSERT_RST(a_cordic_rst, clock, reset, !v0_ff, "cordic valid after reset")
   `ASSERT_CLK(a_cordic_hold, clock, reset, !adv |=> $stable(out_valid), "cordic moved while held")
   `ASSERT_CLK(a_cordic_z, clock, reset, v0_ff |-> (z0_ff <= 32'sd754974720 && z0_ff >= -32'sd754974720), "reduced angle out of range")
endmodule

/* rtl/aavr_matrix.sv */
// Rotation matrix build and vector product, four register stages.
`include "assert_macros.svh"
module aavr_matrix (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic signed [31:0] in_cos,
   input  logic signed [31:0] in_sin,
   input  aavr_pkg::vec_type  in_vec,
   input  aavr_pkg::axis_type in_axis,
   output logic               out_valid,
   output aavr_pkg::vec_type  out_rot
);
   // M1: products p*q and a*s, c1, cq
   logic               v1_ff;
   logic signed [31:0] pq1_ff [3][3];
   logic signed [47:0] as1_ff [3];
   logic signed [32:0] c11_ff;
   logic signed [27:0] cq1_ff;
   aavr_pkg::vec_type  vec1_ff;
   logic signed [32:0] c1_in;
   logic signed [32:0] cr_in;

   assign c1_in = aavr_pkg::ONE_Q30 - 33'(in_cos);
   assign cr_in = (33'(in_cos) + 33'sd8) >>> 4;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
      end
      if (adv) begin
         for (int p = 0; p < 3; p++) begin
            for (int q = 0; q < 3; q++) begin
               pq1_ff[p][q] <= 32'(in_axis[p]) * 32'(in_axis[q]);
            end
            as1_ff[p] <= 48'(in_axis[p]) * 48'(in_sin);
         end
         c11_ff <= c1_in;
         cq1_ff <= cr_in[27:0];
         vec1_ff <= in_vec;
      end
   end

   // M2: matrix entries
   logic               v2_ff;
   logic signed [33:0] m2_ff [3][3];
   aavr_pkg::vec_type  vec2_ff;
   logic signed [63:0] o_in  [3][3];
   logic signed [47:0] sr_in [3];

   always_comb begin
      for (int p = 0; p < 3; p++) begin
         for (int q = 0; q < 3; q++) begin
            o_in[p][q] = ((64'(pq1_ff[p][q]) * 64'(c11_ff)) + 64'sh80000000) >>> 32;
         end
         sr_in[p] = (as1_ff[p] + 48'sd131072) >>> 18;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         m2_ff[0][0] <= 34'(o_in[0][0]) + 34'(cq1_ff);
         m2_ff[0][1] <= 34'(o_in[0][1]) - 34'(sr_in[2]);
         m2_ff[0][2] <= 34'(o_in[0][2]) + 34'(sr_in[1]);
         m2_ff[1][0] <= 34'(o_in[1][0]) + 34'(sr_in[2]);
         m2_ff[1][1] <= 34'(o_in[1][1]) + 34'(cq1_ff);
         m2_ff[1][2] <= 34'(o_in[1][2]) - 34'(sr_in[0]);
         m2_ff[2][0] <= 34'(o_in[2][0]) - 34'(sr_in[1]);
         m2_ff[2][1] <= 34'(o_in[2][1]) + 34'(sr_in[0]);
         m2_ff[2][2] <= 34'(o_in[2][2]) + 34'(cq1_ff);
         vec2_ff <= vec1_ff;
      end
   end

   // M3: products v_j * m_ij
   logic               v3_ff;
   logic signed [65:0] pr3_ff [3][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
               pr3_ff[r][j] <= 66'(vec2_ff[j]) * 66'(m2_ff[r][j]);
            end
         end
      end
   end

   // M4: sum, round, saturate
   logic               v4_ff;
   aavr_pkg::vec_type  rot4_ff;
   logic signed [67:0] acc_in [3];
   logic signed [67:0] sh_in  [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc_in[r] = 68'(pr3_ff[r][0]) + 68'(pr3_ff[r][1]) + 68'(pr3_ff[r][2]);
         sh_in[r] = (acc_in[r] + 68'sd33554432) >>> 26;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            if (sh_in[r] > 68'sd2147483647) begin
               rot4_ff[r] <= 32'sh7fffffff;
            end else if (sh_in[r] < -68'sd2147483648) begin
               rot4_ff[r] <= 32'sh80000000;
            end else begin
               rot4_ff[r] <= sh_in[r][31:0];
            end
         end
      end
   end

   assign out_valid = v4_ff;
   assign out_rot = rot4_ff;

   `ASSERT_RST(a_mat_rst, clock, reset, !v4_ff, "matrix valid after reset")
   `ASSERT_CLK(a_mat_pipe, clock, reset, adv |=> (v2_ff == $past(v1_ff)), "valid lost in matrix")
   `ASSERT_CLK(a_mat_hold, clock, reset, !adv |=> $stable(rot4_ff[0]), "result moved while held")
endmodule

/* rtl/axis_angle_vector_rotate.sv */
// Path from req accept to rsp valid: angle-reduction register, CORDIC stages, matrix stages M1-M4.
// Throughput: one item per cycle; whole pipeline holds on rsp_stall.
// req_stall only follows rsp_stall, so an empty output slot never blocks.
// Reset (synchronous) clears all valid bits; no other state.
`include "assert_macros.svh"
module axis_angle_vector_rotate #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   input  logic signed [15:0] req_axis_x,
   input  logic signed [15:0] req_axis_y,
   input  logic signed [15:0] req_axis_z,
   input  logic signed [16:0] req_angle_deg,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_rot_x,
   output logic signed [31:0] rsp_rot_y,
   output logic signed [31:0] rsp_rot_z
);
   logic               adv;
   logic               cv;
   logic signed [31:0] cc, cs;
   aavr_pkg::vec_type  vin, cvec, rot;
   aavr_pkg::axis_type ain, cax;

   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign vin = '{req_vec_x, req_vec_y, req_vec_z};
   assign ain = '{req_axis_x, req_axis_y, req_axis_z};

   aavr_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(req_valid), .in_angle(req_angle_deg), .in_vec(vin), .in_axis(ain),
      .out_valid(cv), .out_cos(cc), .out_sin(cs), .out_vec(cvec), .out_axis(cax)
   );

   aavr_matrix u_matrix (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(cv), .in_cos(cc), .in_sin(cs), .in_vec(cvec), .in_axis(cax),
      .out_valid(rsp_valid), .out_rot(rot)
   );

   assign rsp_rot_x = rot[0];
   assign rsp_rot_y = rot[1];
   assign rsp_rot_z = rot[2];

   `ASSERT_CLK(a_top_stall, clock, reset, req_stall |-> (rsp_valid && rsp_stall), "input held with no output backlog")
   `ASSERT_CLK(a_top_hold, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid, "result dropped under stall")
   `ASSERT_CLK(a_top_data, clock, reset, (rsp_valid && rsp_stall) |=> $stable(rsp_rot_x), "result changed under stall")
endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
   localparam int STAGES = 16;
   localparam int LATENCY = STAGES + 5;

   typedef struct {
      logic signed [31:0] x, y, z;
   } rot_t;

   typedef struct {
      logic signed [31:0] vx, vy, vz;
      logic signed [15:0] ax, ay, az;
      logic signed [16:0] ang;
   } rot_req_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_vec_x = '0, req_vec_y = '0, req_vec_z = '0;
   logic signed [15:0] req_axis_x = '0, req_axis_y = '0, req_axis_z = '0;
   logic signed [16:0] req_angle_deg = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_rot_x, rsp_rot_y, rsp_rot_z;

   rot_t pending_rots[$];
   int mismatch_count = 0;
   bit send_idle_en = 1'b0;
   bit recv_idle_en = 1'b0;
   int hold_off_cycles = 0;

   axis_angle_vector_rotate #(.CORDIC_STAGES(STAGES)) dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   localparam longint ATAN_Q23 [24] = '{
      377487360, 222843801, 117744544, 59768969, 30000467, 15014858, 7509261,
      3754860, 1877459, 938733, 469367, 234683, 117342, 58671, 29335, 14668,
      7334, 3667, 1833, 917, 458, 229, 115, 57};

   function automatic longint round_shift(longint v, int k);
      return (v + (64'sd1 <<< (k - 1))) >>> k;
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic rot_t rotate_vector(rot_req_t r);
      longint a, x, y, z, t, c, s, c1, cq, acc;
      longint v[3], ax[3], m[3][3];
      bit flip;
      rot_t o;
      a = longint'(r.ang) % 46080;
      flip = 0;
      if (a > 23040) a -= 46080;
      if (a < -23040) a += 46080;
      if (a > 11520) begin
         a -= 23040; flip = 1;
      end else if (a < -11520) begin
         a += 23040; flip = 1;
      end
      x = 652032874; y = 0; z = a * 65536;
      for (int i = 0; i < STAGES && i < 24; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i); y = y + (x >>> i); z -= ATAN_Q23[i];
         end else begin
            t = x + (y >>> i); y = y - (x >>> i); z += ATAN_Q23[i];
         end
         x = t;
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = x; s = y;
      c1 = 64'sd1073741824 - c;
      cq = round_shift(c, 4);
      v = '{r.vx, r.vy, r.vz};
      ax = '{r.ax, r.ay, r.az};
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            m[i][j] = round_shift(ax[i] * ax[j] * c1, 32);
      for (int i = 0; i < 3; i++) m[i][i] += cq;
      m[0][1] -= round_shift(ax[2] * s, 18);
      m[0][2] += round_shift(ax[1] * s, 18);
      m[1][0] += round_shift(ax[2] * s, 18);
      m[1][2] -= round_shift(ax[0] * s, 18);
      m[2][0] -= round_shift(ax[1] * s, 18);
      m[2][1] += round_shift(ax[0] * s, 18);
      acc = v[0] * m[0][0] + v[1] * m[0][1] + v[2] * m[0][2];
      o.x = clamp32(round_shift(acc, 26));
      acc = v[0] * m[1][0] + v[1] * m[1][1] + v[2] * m[1][2];
      o.y = clamp32(round_shift(acc, 26));
      acc = v[0] * m[2][0] + v[1] * m[2][1] + v[2] * m[2][2];
      o.z = clamp32(round_shift(acc, 26));
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0d want %0d at %0t", what, $signed(got),
         $signed(want), $realtime);
      mismatch_count++;
   endtask

   // valid stays high after an item; idle bursts and wait_drained drop it
   task automatic send_item(rot_req_t r);
      if (send_idle_en && $urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 19)) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      req_valid <= 1'b1;
      req_vec_x <= r.vx; req_vec_y <= r.vy; req_vec_z <= r.vz;
      req_axis_x <= r.ax; req_axis_y <= r.ay; req_axis_z <= r.az;
      req_angle_deg <= r.ang;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rots.push_back(rotate_vector(r));
      @(negedge clock);
   endtask

   // receiver side: random stall bursts or a counted long hold-off
   initial begin
      @(negedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_off_cycles) @(negedge clock);
            hold_off_cycles = 0;
         end else if (recv_idle_en && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      rot_t e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rots.size() == 0) begin
            $display("MISMATCH unexpected item at %0t", $realtime);
            mismatch_count++;
         end else begin
            e = pending_rots.pop_front();
            if (rsp_rot_x !== e.x) report_mismatch("rot_x", rsp_rot_x, e.x);
            if (rsp_rot_y !== e.y) report_mismatch("rot_y", rsp_rot_y, e.y);
            if (rsp_rot_z !== e.z) report_mismatch("rot_z", rsp_rot_z, e.z);
         end
      end
   end

   function automatic logic signed [15:0] rand_axis();
      return 16'($urandom_range(0, 32768)) - 16'sd16384;
   endfunction

   function automatic rot_req_t rand_req();
      rot_req_t r;
      r.vx = $urandom; r.vy = $urandom; r.vz = $urandom;
      if ($urandom_range(0, 1)) begin
         r.vx = $signed(r.vx) >>> $urandom_range(0, 31);
         r.vy = $signed(r.vy) >>> $urandom_range(0, 31);
         r.vz = $signed(r.vz) >>> $urandom_range(0, 31);
      end
      case ($urandom_range(0, 3))
         0: begin
            r.ax = 16'($urandom); r.ay = 16'($urandom); r.az = 16'($urandom);
         end
         1: begin
            r.ax = '0; r.ay = '0; r.az = '0;
            case ($urandom_range(0, 2))
               0: r.ax = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
               1: r.ay = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
               default: r.az = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            endcase
         end
         default: begin
            r.ax = rand_axis(); r.ay = rand_axis(); r.az = rand_axis();
         end
      endcase
      r.ang = $urandom_range(0, 3) == 0 ? 17'($urandom)
         : 17'($urandom_range(0, 92160)) - 17'sd46080;
      return r;
   endfunction

   function automatic rot_req_t mk(int vx, int vy, int vz, int ax, int ay,
         int az, int ang);
      rot_req_t r;
      r.vx = vx; r.vy = vy; r.vz = vz;
      r.ax = 16'(ax); r.ay = 16'(ay); r.az = 16'(az); r.ang = 17'(ang);
      return r;
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_rots.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      int angles[10] = '{0, 11520, -11520, 23040, -23040, 46080, -46080,
         11521, 65535, -65536};
      foreach (angles[i]) send_item(mk(65536, 65536, 65536, 0, 0, 16384, angles[i]));
      send_item(mk(0, 65536, 0, 16384, 0, 0, 5760));
      send_item(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16384, 16384, 16384, 0));
      send_item(mk(32'h80000000, 32'h80000000, 32'h80000000, -16384, -16384, -16384,
         23040));
      send_item(mk(32'h7fffffff, 32'h80000000, -1, 32767, -32768, 1, 3000));
      send_item(mk(-1, 1, 32'h80000000, -32768, 32767, -1, -3000));
      send_item(mk(123456, -654321, 98765, 9459, 9459, 9459, 15360));
      send_item(mk(65536, 0, 0, 8192, 8192, 0, 46079));
      send_item(mk(0, 0, 0, 0, 0, 0, 1));
      wait_drained();
   endtask

   task automatic test_random_idle();
      send_idle_en = 1; recv_idle_en = 1;
      repeat (450) send_item(rand_req());
   endtask

   task automatic test_backpressure();
      hold_off_cycles = 200;
      repeat (60) send_item(rand_req());
      wait_drained();
      repeat (20) send_item(rand_req());
      wait_drained();
   endtask

   task automatic test_full_rate();
      send_idle_en = 0; recv_idle_en = 0;
      @(negedge clock);
      repeat (250) send_item(rand_req());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random_idle();
      test_backpressure();
      test_full_rate();
      wait_drained();
      repeat (LATENCY + 10) @(negedge clock);
      if (mismatch_count == 0 && pending_rots.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end
endmodule

/* filelist.f */
+incdir+rtl
rtl/aavr_pkg.sv
rtl/aavr_cordic.sv
rtl/aavr_matrix.sv
rtl/axis_angle_vector_rotate.sv
tb/sv/testbench.sv
